// File: hdl/i2csd_pkg.sv
// ----------------------------------------------------------------------------
// I2C SCL divisor search: shared package
// Field widths, fixed constants and the structs that pass between the
// sequencer, the serial divider and the top level.
// ----------------------------------------------------------------------------
package i2csd_pkg;

    localparam int REQ_W  = 20;  // requested rate
    localparam int CTRL_W = 32;  // control word
    localparam int DIV_W  = 32;  // divider dividend and quotient
    localparam int DEN_W  = 25;  // divider divisor, holds 22 * 1000000
    localparam int RATE_W = 28;  // any quotient of the clock by 22 or more

    localparam logic [31:0] CLK_HZ_RESET = 32'd111111111;

    typedef struct packed {
        logic              pending;
        logic [CTRL_W-1:0] ctrl;
        logic [REQ_W-1:0]  req;
    } t_item;

    typedef struct packed {
        logic              status;
        logic [5:0]        div_b;
        logic [1:0]        div_a;
        logic [CTRL_W-1:0] new_control;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DEN_W-1:0] rem;
    } t_div_rsp;

endpackage

// File: hdl/i2csd_div.sv
// ----------------------------------------------------------------------------
// I2C SCL divisor search: serial divider
// Restoring divider, one quotient bit per cycle. A start loads the operands;
// done pulses for one cycle when quotient and remainder are ready and they
// hold until the next start.
// ----------------------------------------------------------------------------
module i2csd_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2csd_pkg::t_div_req i_req,
    output i2csd_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(i2csd_pkg::DIV_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [i2csd_pkg::DEN_W-1:0] r_rem;
    logic [i2csd_pkg::DIV_W-1:0] r_quo;
    logic [i2csd_pkg::DEN_W-1:0] r_den;

    logic [i2csd_pkg::DEN_W:0]   n_shift;
    logic                        n_bit;
    logic [i2csd_pkg::DEN_W-1:0] n_rem;

    always_comb begin
        n_shift = {r_rem, r_quo[i2csd_pkg::DIV_W-1]};
        n_bit   = (n_shift >= {1'b0, r_den});
        if (n_bit) begin
            n_rem = i2csd_pkg::DEN_W'(n_shift - {1'b0, r_den});
        end else begin
            n_rem = i2csd_pkg::DEN_W'(n_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(i2csd_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[i2csd_pkg::DIV_W-2:0], n_bit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// File: hdl/i2csd_ctl.sv
// ----------------------------------------------------------------------------
// I2C SCL divisor search: sequencer
// Clamps the request, forms the base product, then walks divisor B for one
// or two base products, issuing every division to the shared divider and
// keeping the pair with the least rate error.
// ----------------------------------------------------------------------------
module i2csd_ctl #(
    parameter int DIVB_STEPS = 64,
    parameter int DIVA_LIMIT = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  i2csd_pkg::t_item    i_item,
    input  logic [31:0]         i_clk_hz,
    output logic                o_idle,
    output logic                o_res_valid,
    output i2csd_pkg::t_result  o_res,
    input  logic                i_res_ack,
    output i2csd_pkg::t_div_req o_div_req,
    input  i2csd_pkg::t_div_rsp i_div_rsp
);

    localparam int BW = $clog2(DIVB_STEPS);
    localparam int AW = $clog2(DIVA_LIMIT + 1);
    localparam int MW = AW + BW + 2;

    localparam logic [i2csd_pkg::REQ_W-1:0] REQ_MAX  = 20'd1000000;
    localparam logic [i2csd_pkg::REQ_W-1:0] FAST_CAP = 20'd384600;
    localparam logic [i2csd_pkg::REQ_W-1:0] STD_LOW  = 20'd90000;
    localparam logic [i2csd_pkg::REQ_W-1:0] STD_HIGH = 20'd100000;
    localparam logic [31:0] CTRL_KEEP_MASK = 32'hFFFF00FF;
    localparam int DIVA_POS = 14;
    localparam int DIVB_POS = 8;

    typedef enum logic [3:0] {
        S_IDLE, S_PROD_ST, S_PROD_WT, S_REM_ST, S_REM_WT,
        S_A_ST, S_A_WT, S_R_ST, S_R_WT, S_NEXT, S_DONE
    } t_state;

    t_state                           r_state;
    logic [i2csd_pkg::CTRL_W-1:0]     r_ctrl;
    logic [i2csd_pkg::REQ_W-1:0]      r_req;
    logic [i2csd_pkg::REQ_W-1:0]      r_rc;
    logic [i2csd_pkg::RATE_W-1:0]     r_p;
    logic                             r_two;
    logic                             r_second;
    logic [BW-1:0]                    r_b;
    logic [AW-1:0]                    r_a;
    logic [i2csd_pkg::RATE_W-1:0]     r_err;
    logic [AW-1:0]                    r_best_a;
    logic [BW-1:0]                    r_best_b;
    i2csd_pkg::t_result               r_res;

    logic [i2csd_pkg::REQ_W-1:0]      n_req;
    logic [i2csd_pkg::REQ_W-1:0]      n_rc;
    logic [BW:0]                      n_bp1;
    logic [MW-1:0]                    n_ab;
    logic [i2csd_pkg::RATE_W-1:0]     n_rate;
    logic [i2csd_pkg::RATE_W-1:0]     n_rc_ext;
    logic [i2csd_pkg::RATE_W-1:0]     n_err;

    // 22 * x as shifts and adds.
    function automatic logic [i2csd_pkg::DEN_W-1:0] times_scl(
        input logic [i2csd_pkg::REQ_W-1:0] x
    );
        logic [i2csd_pkg::DEN_W-1:0] w;
        w = i2csd_pkg::DEN_W'(x);
        return (w << 4) + (w << 2) + (w << 1);
    endfunction

    always_comb begin
        n_req = i_item.req;
        if (i_item.req == '0) begin
            n_req = i2csd_pkg::REQ_W'(1);
        end else if (i_item.req > REQ_MAX) begin
            n_req = REQ_MAX;
        end
        n_rc = n_req;
        if (n_req > FAST_CAP) begin
            n_rc = FAST_CAP;
        end else if (n_req > STD_LOW && n_req <= STD_HIGH) begin
            n_rc = STD_LOW;
        end
    end

    always_comb begin
        n_bp1    = {1'b0, r_b} + (BW + 1)'(1);
        n_ab     = MW'(({1'b0, r_a} + (AW + 1)'(1))) * MW'(n_bp1);
        n_rate   = i_div_rsp.quot[i2csd_pkg::RATE_W-1:0];
        n_rc_ext = i2csd_pkg::RATE_W'(r_rc);
        if (n_rate > n_rc_ext) begin
            n_err = n_rate - n_rc_ext;
        end else begin
            n_err = n_rc_ext - n_rate;
        end
    end

    always_comb begin
        o_div_req.start    = 1'b0;
        o_div_req.dividend = i_clk_hz;
        o_div_req.divisor  = times_scl(r_req);
        case (r_state)
            S_PROD_ST: begin
                o_div_req.start = 1'b1;
            end
            S_REM_ST: begin
                o_div_req.start   = 1'b1;
                o_div_req.divisor = times_scl(r_rc);
            end
            S_A_ST: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = i2csd_pkg::DIV_W'(r_p);
                o_div_req.divisor  = i2csd_pkg::DEN_W'(n_bp1);
            end
            S_R_ST: begin
                o_div_req.start   = 1'b1;
                o_div_req.divisor = times_scl(i2csd_pkg::REQ_W'(n_ab));
            end
            default: begin
                o_div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ctrl <= i_item.ctrl;
                        r_req  <= n_req;
                        r_rc   <= n_rc;
                        if (i_item.pending) begin
                            r_res.new_control <= i_item.ctrl;
                            r_res.div_a       <= '0;
                            r_res.div_b       <= '0;
                            r_res.status      <= 1'b1;
                            r_state           <= S_DONE;
                        end else begin
                            r_state <= S_PROD_ST;
                        end
                    end
                end
                S_PROD_ST: r_state <= S_PROD_WT;
                S_PROD_WT: begin
                    if (i_div_rsp.done) begin
                        r_p     <= i_div_rsp.quot[i2csd_pkg::RATE_W-1:0];
                        r_state <= S_REM_ST;
                    end
                end
                S_REM_ST: r_state <= S_REM_WT;
                S_REM_WT: begin
                    if (i_div_rsp.done) begin
                        r_two    <= (i_div_rsp.rem != '0);
                        r_second <= 1'b0;
                        r_b      <= '0;
                        r_err    <= i2csd_pkg::RATE_W'(r_rc);
                        r_best_a <= '0;
                        r_best_b <= '0;
                        r_state  <= S_A_ST;
                    end
                end
                S_A_ST: r_state <= S_A_WT;
                S_A_WT: begin
                    if (i_div_rsp.done) begin
                        // Divisor A would exceed its field: skip this B.
                        if (i_div_rsp.quot > i2csd_pkg::DIV_W'(DIVA_LIMIT + 1)) begin
                            r_state <= S_NEXT;
                        end else begin
                            if (i_div_rsp.quot == '0) begin
                                r_a <= '0;
                            end else begin
                                r_a <= AW'(i_div_rsp.quot - i2csd_pkg::DIV_W'(1));
                            end
                            r_state <= S_R_ST;
                        end
                    end
                end
                S_R_ST: r_state <= S_R_WT;
                S_R_WT: begin
                    if (i_div_rsp.done) begin
                        if (n_err < r_err) begin
                            r_err    <= n_err;
                            r_best_a <= r_a;
                            r_best_b <= r_b;
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_b == BW'(DIVB_STEPS - 1)) begin
                        if (r_two && !r_second) begin
                            r_second <= 1'b1;
                            r_p      <= r_p + i2csd_pkg::RATE_W'(1);
                            r_b      <= '0;
                            r_state  <= S_A_ST;
                        end else begin
                            r_res.new_control <= (r_ctrl & CTRL_KEEP_MASK)
                                | (32'(r_best_a) << DIVA_POS)
                                | (32'(r_best_b) << DIVB_POS);
                            r_res.div_a       <= 2'(r_best_a);
                            r_res.div_b       <= 6'(r_best_b);
                            r_res.status      <= 1'b0;
                            r_state           <= S_DONE;
                        end
                    end else begin
                        r_b     <= r_b + BW'(1);
                        r_state <= S_A_ST;
                    end
                end
                S_DONE: begin
                    if (i_res_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// File: hdl/i2c_scl_divisor_search.sv
// ----------------------------------------------------------------------------
// I2C SCL divisor search: top level
// Picks divisors A and B of an I2C controller for a requested SCL rate and
// merges them into the control word.
// ----------------------------------------------------------------------------
// One request is worked at a time; s_axis_tready is high only while the
// sequencer is idle. Every division goes through one shared divider. A
// request does two set-up divisions, then for each of one or two base
// products one division per divisor B and a second one for each B whose
// divisor A fits. A request with transfer_pending set skips the divisions.
// A finished result waits in the output register, and the next request is
// taken while it waits.
module i2c_scl_divisor_search #(
    parameter int DIVB_STEPS = 64,
    parameter int DIVA_LIMIT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: input_clock_hz.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // Bits from 0 up: requested_hz[19:0], current_control[51:20],
    // transfer_pending[52], zero pad[55:53].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    // Bits from 0 up: new_control[31:0], div_a[33:32], div_b[39:34],
    // status[40], zero pad[47:41].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata
);

    logic [31:0]         r_clk_hz;
    logic                r_m_valid;
    i2csd_pkg::t_result  r_m_res;

    i2csd_pkg::t_item    n_item;
    i2csd_pkg::t_result  n_res;
    i2csd_pkg::t_div_req n_div_req;
    i2csd_pkg::t_div_rsp n_div_rsp;
    logic                n_idle;
    logic                n_res_valid;
    logic                n_load;
    logic                n_accept;

    assign n_item.req     = s_axis_tdata[19:0];
    assign n_item.ctrl    = s_axis_tdata[51:20];
    assign n_item.pending = s_axis_tdata[52];

    assign s_axis_tready = n_idle;
    assign n_accept      = s_axis_tvalid & n_idle;
    assign o_cfg_ready   = 1'b1;

    // The output register takes a result whenever it is empty or being drained.
    assign n_load = n_res_valid & (~r_m_valid | m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz  <= i2csd_pkg::CLK_HZ_RESET;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_clk_hz <= i_cfg_data;
            end
            if (n_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_m_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'b0, r_m_res.status, r_m_res.div_b,
                            r_m_res.div_a, r_m_res.new_control};

    i2csd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (n_div_rsp)
    );

    i2csd_ctl #(
        .DIVB_STEPS (DIVB_STEPS),
        .DIVA_LIMIT (DIVA_LIMIT)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (n_accept),
        .i_item      (n_item),
        .i_clk_hz    (r_clk_hz),
        .o_idle      (n_idle),
        .o_res_valid (n_res_valid),
        .o_res       (n_res),
        .i_res_ack   (n_load),
        .o_div_req   (n_div_req),
        .i_div_rsp   (n_div_rsp)
    );

endmodule

// File: verif/i2c_scl_divisor_search_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C SCL divisor search: block-level test
// Sends rate requests under several reference clock settings, predicts the
// divisor pair and the merged control word for each accepted request, and
// compares every returned beat with the oldest prediction. Both stream sides
// idle in random bursts, and the result side holds off once for a long time.
// ----------------------------------------------------------------------------
module i2c_scl_divisor_search_test;

    localparam int DIVB_STEPS = 64;
    localparam int DIVA_LIMIT = 3;

    localparam logic [63:0] SCL_FACTOR = 64'd22;
    localparam logic [63:0] FAST_CAP   = 64'd384600;
    localparam logic [63:0] STD_FLOOR  = 64'd90000;
    localparam logic [63:0] STD_CEIL   = 64'd100000;
    localparam logic [63:0] REQ_CEIL   = 64'd1000000;
    localparam logic [31:0] CTRL_KEEP  = 32'hFFFF_00FF;

    localparam logic [31:0] CLK_HZ_MIN = 32'd1000000;
    localparam logic [31:0] CLK_HZ_MAX = 32'hFFFF_FFFF;

    localparam int HOLD_CYCLES = 30000;

    typedef enum logic {
        SCL_OK   = 1'b0,
        SCL_BUSY = 1'b1
    } t_scl_status;

    class scl_divisor_board;
        i2csd_pkg::t_result expected_q[$];
        logic [31:0]        clock_hz;
        int                 mismatches;

        function new();
            clock_hz   = i2csd_pkg::CLK_HZ_RESET;
            mismatches = 0;
        endfunction

        function void set_clock(logic [31:0] hz);
            clock_hz = hz;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Searches one or two base products for the divisor pair whose SCL
        // rate lands closest to the clamped request.
        function i2csd_pkg::t_result predict_divisors(i2csd_pkg::t_item it);
            i2csd_pkg::t_result res;
            logic [63:0] clk, req, prod, prod_last, p;
            logic [63:0] best_err, best_a, best_b;
            logic [63:0] last_err, cand_a, cand_b, a, rate, err;
            int          b;
            clk = {32'd0, clock_hz};
            res = '0;
            if (it.pending) begin
                res.new_control = it.ctrl;
                res.status      = SCL_BUSY;
                return res;
            end
            req = {44'd0, it.req};
            if (req == 0) req = 1;
            if (req > REQ_CEIL) req = REQ_CEIL;
            // The base product comes from the rate before the fast and standard caps.
            prod = clk / (SCL_FACTOR * req);
            if (req > FAST_CAP) begin
                req = FAST_CAP;
            end else if (req > STD_FLOOR && req <= STD_CEIL) begin
                req = STD_FLOOR;
            end
            prod_last = ((clk % (SCL_FACTOR * req)) != 0) ? prod + 1 : prod;
            best_err  = req;
            best_a    = 0;
            best_b    = 0;
            for (p = prod; p <= prod_last; p++) begin
                last_err = req;
                cand_a   = 0;
                cand_b   = 0;
                for (b = 0; b < DIVB_STEPS; b++) begin
                    a = p / (b + 1);
                    if (a != 0) a = a - 1;
                    if (a > DIVA_LIMIT) continue;
                    rate = clk / (SCL_FACTOR * (a + 1) * (b + 1));
                    err  = (rate > req) ? rate - req : req - rate;
                    if (last_err > err) begin
                        cand_a   = a;
                        cand_b   = b;
                        last_err = err;
                    end
                end
                // The second base product wins only on a strictly smaller error.
                if (last_err < best_err) begin
                    best_err = last_err;
                    best_a   = cand_a;
                    best_b   = cand_b;
                end
            end
            res.div_a       = best_a[1:0];
            res.div_b       = best_b[5:0];
            res.new_control = (it.ctrl & CTRL_KEEP) | (32'(best_a[1:0]) << 14)
                            | (32'(best_b[5:0]) << 8);
            res.status      = SCL_OK;
            return res;
        endfunction

        function void note_request(i2csd_pkg::t_item it);
            expected_q.push_back(predict_divisors(it));
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime,
                     what, got, want);
            mismatches++;
        endtask

        task check_result(i2csd_pkg::t_result got);
            i2csd_pkg::t_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected beat, new_control", got.new_control, 32'd0);
                return;
            end
            want = expected_q.pop_front();
            if (got.new_control !== want.new_control)
                report_mismatch("new_control", got.new_control, want.new_control);
            if (got.div_a !== want.div_a)
                report_mismatch("div_a", 32'(got.div_a), 32'(want.div_a));
            if (got.div_b !== want.div_b)
                report_mismatch("div_b", 32'(got.div_b), 32'(want.div_b));
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // req[19:0], ctrl[51:20], pending[52], pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // new_control[31:0], a[33:32], b[39:34], status[40]

    // The stimulus sets calm and hold_request; the result side reads them and sets hold_done.
    bit calm = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;

    scl_divisor_board board = new();

    always #2 i_clk = ~i_clk;

    i2c_scl_divisor_search #(
        .DIVB_STEPS(DIVB_STEPS),
        .DIVA_LIMIT(DIVA_LIMIT)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    task automatic send_request(input logic [19:0] req, input logic [31:0] ctrl,
                                input logic pending);
        i2csd_pkg::t_item it;
        int               gap;
        it.req     = req;
        it.ctrl    = ctrl;
        it.pending = pending;
        if (!calm && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, pending, ctrl, req};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(it);
    endtask

    task automatic send_random_request();
        logic [19:0] edges[11] = '{20'd0, 20'd1, 20'd90000, 20'd90001, 20'd100000,
                                   20'd100001, 20'd384600, 20'd384601, 20'd1000000,
                                   20'd1000001, 20'hFFFFF};
        logic [19:0] req;
        case ($urandom_range(0, 9))
            0:       req = 20'($urandom_range(0, 20'hFFFFF));
            1:       req = edges[$urandom_range(0, 10)];
            2, 3:    req = 20'($urandom_range(10000, 100000));
            4, 5, 6: req = 20'($urandom_range(100001, 400000));
            7:       req = 20'($urandom_range(1, 10000));
            8:       req = 20'($urandom_range(400001, 20'hFFFFF));
            default: req = 20'($urandom_range(89990, 100010));
        endcase
        send_request(req, $urandom, $urandom_range(0, 6) == 0);
    endtask

    // Waits until every predicted beat has come back.
    task automatic drain_results();
        while (board.outstanding() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_clock_hz(input logic [31:0] hz);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= hz;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.set_clock(hz);
    endtask

    // The request valid drops right after the last beat is taken, so the
    // block never sees that beat a second time once it is idle again.
    task automatic run_random(input int count);
        repeat (count) send_random_request();
        s_axis_tvalid <= 1'b0;
        drain_results();
    endtask

    initial begin : result_sink
        int stall_left;
        int run_left;
        int hold_left;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(i2csd_pkg::t_result'(m_axis_tdata[40:0]));
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                run_left = $urandom_range(0, 80);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset clock: clamp boundaries, saturation, zero request and busy.
        send_request(20'd0,       32'h0000_0000, 1'b0);
        send_request(20'd1,       32'hFFFF_FFFF, 1'b0);
        send_request(20'hFFFFF,   32'hFFFF_FFFF, 1'b0);
        send_request(20'd1000000, 32'h1234_5678, 1'b0);
        send_request(20'd1000001, 32'h0000_0000, 1'b0);
        send_request(20'd384600,  32'hFFFF_FFFF, 1'b0);
        send_request(20'd384601,  32'hA5A5_5A5A, 1'b0);
        send_request(20'd400000,  32'h5A5A_A5A5, 1'b0);
        send_request(20'd100000,  32'hFFFF_FFFF, 1'b0);
        send_request(20'd100001,  32'h0000_0000, 1'b0);
        send_request(20'd90000,   32'hDEAD_BEEF, 1'b0);
        send_request(20'd90001,   32'h0F0F_F0F0, 1'b0);
        send_request(20'd95000,   32'hF0F0_0F0F, 1'b0);
        send_request(20'd50000,   32'h8000_0001, 1'b0);
        send_request(20'd10000,   32'h7FFF_FFFE, 1'b0);
        send_request(20'd100,     32'hFFFF_FFFF, 1'b0);
        send_request(20'd100000,  32'hFFFF_FFFF, 1'b1);
        send_request(20'd0,       32'h0000_0000, 1'b1);
        send_request(20'hFFFFF,   32'hA5A5_5A5A, 1'b1);
        run_random(5);

        // Slowest allowed reference clock: many rates find no usable pair.
        write_clock_hz(CLK_HZ_MIN);
        run_random(16);

        write_clock_hz(CLK_HZ_MAX);
        run_random(16);

        // The result side stops for a long stretch while requests keep coming.
        write_clock_hz($urandom_range(CLK_HZ_MIN, 200000000));
        hold_request = 1'b1;
        run_random(16);

        write_clock_hz($urandom_range(CLK_HZ_MIN, CLK_HZ_MAX));
        run_random(16);

        write_clock_hz($urandom_range(20000000, 150000000));
        calm = 1'b1;
        run_random(16);

        repeat (100) @(posedge i_clk);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("i2c_scl_divisor_search verification clean");
        end else begin
            $display("i2c_scl_divisor_search verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("i2c_scl_divisor_search verification failed");
        $finish;
    end

endmodule
